// ----- src/gasl_pkg.sv -----
// gasl_pkg: types, constants and helpers for the gravity aware slew limiter
// used by every module of the block, depends on nothing
package gasl_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int CALC_WIDTH = VALUE_WIDTH + 3;
	localparam int ONE_INT = 1 << (VALUE_WIDTH - 2);
	localparam int IDX_WIDTH = 2;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic signed [CALC_WIDTH-1:0] calc_t;
	typedef logic [VALUE_WIDTH-2:0] step_t;

	localparam step_t ACCEL_RESET = step_t'(ONE_INT / 10);
	localparam step_t DECEL_RESET = step_t'(-(ONE_INT / 10));
	localparam value_t WEAK_RESET = '0;
	localparam value_t STRONG_RESET = value_t'(ONE_INT / 10);

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_ACCEL_STEP = 2'd0,
		REG_DECEL_STEP = 2'd1,
		REG_WEAK_LEVEL = 2'd2,
		REG_STRONG_LEVEL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		step_t accel_step;
		step_t decel_step;
		value_t weak_gravity_level;
		value_t strong_gravity_level;
	} cfg_regs_t;

	function automatic value_t clamp_one(input calc_t v);
		calc_t one_c;
		one_c = calc_t'(ONE_INT);
		if (v > one_c) begin
			return value_t'(one_c);
		end else if (v < -one_c) begin
			return value_t'(-one_c);
		end
		return value_t'(v);
	endfunction

endpackage

// ----- src/gasl_cfg.sv -----
// gasl_cfg: configuration register file of the slew limiter
// depends on gasl_pkg
module gasl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [gasl_pkg::IDX_WIDTH-1:0]   wr_index,
	input  logic [gasl_pkg::VALUE_WIDTH-1:0] wr_data,
	output gasl_pkg::cfg_regs_t           regs
);

	gasl_pkg::cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.accel_step <= gasl_pkg::ACCEL_RESET;
			regs_q.decel_step <= gasl_pkg::DECEL_RESET;
			regs_q.weak_gravity_level <= gasl_pkg::WEAK_RESET;
			regs_q.strong_gravity_level <= gasl_pkg::STRONG_RESET;
		end else if (wr_en) begin
			case (gasl_pkg::reg_idx_t'(wr_index))
				gasl_pkg::REG_ACCEL_STEP: begin
					regs_q.accel_step <= wr_data[gasl_pkg::VALUE_WIDTH-2:0];
				end
				gasl_pkg::REG_DECEL_STEP: begin
					regs_q.decel_step <= wr_data[gasl_pkg::VALUE_WIDTH-2:0];
				end
				gasl_pkg::REG_WEAK_LEVEL: begin
					regs_q.weak_gravity_level <= gasl_pkg::value_t'(wr_data);
				end
				gasl_pkg::REG_STRONG_LEVEL: begin
					regs_q.strong_gravity_level <= gasl_pkg::value_t'(wr_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ----- src/gasl_step.sv -----
// gasl_step: one limiter tick, new level and both saturated motor commands
// depends on gasl_pkg
module gasl_step (
	input  gasl_pkg::value_t    target_speed,
	input  gasl_pkg::value_t    correction,
	input  gasl_pkg::value_t    level_cur,
	input  gasl_pkg::cfg_regs_t regs,
	output gasl_pkg::value_t    left_drive,
	output gasl_pkg::value_t    right_drive,
	output gasl_pkg::value_t    drive_level
);

	gasl_pkg::calc_t req, corr, cur, a, d, wk, st, diff, next_c, lvl;
	gasl_pkg::value_t next_v;

	always_comb begin
		req = gasl_pkg::calc_t'(target_speed);
		corr = gasl_pkg::calc_t'(correction);
		cur = gasl_pkg::calc_t'(level_cur);
		a = gasl_pkg::calc_t'({1'b0, regs.accel_step});
		d = gasl_pkg::calc_t'($signed(regs.decel_step));
		wk = gasl_pkg::calc_t'(regs.weak_gravity_level);
		st = gasl_pkg::calc_t'(regs.strong_gravity_level);
		diff = req - cur;
		if (diff > 0) begin
			if (diff < a) begin
				next_c = req;
			end else if ((cur + a > wk) && (cur < st)) begin
				if (cur > wk) begin
					next_c = (req < st + a) ? req : st + a;
				end else begin
					next_c = (req < st) ? req : cur + a + st - wk;
				end
			end else begin
				next_c = cur + a;
			end
		end else begin
			if (diff > d) begin
				next_c = req;
			end else if ((cur + d < st) && (cur > wk)) begin
				if (cur < st) begin
					next_c = (req > wk + d) ? req : wk + d;
				end else begin
					next_c = (req > wk) ? req : cur + d - st + wk;
				end
			end else begin
				next_c = cur + d;
			end
		end
		next_v = gasl_pkg::clamp_one(next_c);
		lvl = gasl_pkg::calc_t'(next_v);
	end

	assign drive_level = next_v;
	assign left_drive = gasl_pkg::clamp_one(-lvl - corr);
	assign right_drive = gasl_pkg::clamp_one(lvl + corr);

endmodule

// ----- src/gravity_aware_slew_limiter.sv -----
// gravity_aware_slew_limiter: top level, input register, limiter tick, result register
// depends on gasl_pkg, gasl_cfg, gasl_step
//
// channel  | direction | handshake                    | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | target_speed, correction
// m_axis   | out       | m_axis_tvalid / m_axis_tready | left_drive, right_drive, drive_level
// cfg      | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// one item per cycle while m_axis_tready stays high; each item passes the input register
// and then the result register, whose valid bit drives m_axis_tvalid
// the stored level updates as an item moves from the input register to the result register,
// so the next item in the input register already sees it
// a stalled result register holds the input register, s_axis_tready falls only when both are full
// reset clears both valid bits, the stored level and the registers to their defaults
module gravity_aware_slew_limiter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [2*gasl_pkg::VALUE_WIDTH-1:0] s_axis_tdata,  // target_speed, correction
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [3*gasl_pkg::VALUE_WIDTH-1:0] m_axis_tdata,  // left_drive, right_drive, drive_level
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gasl_pkg::IDX_WIDTH-1:0]      cfg_index,
	input  logic [gasl_pkg::VALUE_WIDTH-1:0]    cfg_data
);

	localparam int VW = gasl_pkg::VALUE_WIDTH;

	gasl_pkg::cfg_regs_t regs;
	logic valid_s1, valid_s2, advance;
	gasl_pkg::value_t req_s1, corr_s1;
	gasl_pkg::value_t left_s2, right_s2, level_s2;
	gasl_pkg::value_t level_q;
	gasl_pkg::value_t left_d, right_d, level_d;

	assign cfg_ready = 1'b1;

	gasl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs)
	);

	gasl_step u_step (
		.target_speed (req_s1),
		.correction   (corr_s1),
		.level_cur    (level_q),
		.regs         (regs),
		.left_drive   (left_d),
		.right_drive  (right_d),
		.drive_level  (level_d)
	);

	assign advance = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			level_q <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				level_q <= level_d;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid & s_axis_tready) begin
			req_s1 <= gasl_pkg::value_t'(s_axis_tdata[VW-1:0]);
			corr_s1 <= gasl_pkg::value_t'(s_axis_tdata[2*VW-1:VW]);
		end
		if (advance) begin
			left_s2 <= left_d;
			right_s2 <= right_d;
			level_s2 <= level_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {level_s2, right_s2, left_s2};

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (level_s2 <= gasl_pkg::value_t'(gasl_pkg::ONE_INT))
			&& (level_s2 >= -gasl_pkg::value_t'(gasl_pkg::ONE_INT)))
		else $error("drive level outside full scale");

	a_right_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (right_s2 <= gasl_pkg::value_t'(gasl_pkg::ONE_INT))
			&& (right_s2 >= -gasl_pkg::value_t'(gasl_pkg::ONE_INT)))
		else $error("right drive not saturated");

	a_level_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (level_q == level_s2))
		else $error("stored level differs from delivered level");

	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(level_q))
		else $error("stored level moved without a tick");

	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

endmodule

// ----- sim/gravity_aware_slew_limiter_tb.sv -----
// gravity_aware_slew_limiter_tb: self-checking bench for the gravity aware slew limiter
// directed table then random phases, each result checked by a predictor or a fixed row
// depends on gasl_pkg and gravity_aware_slew_limiter
module gravity_aware_slew_limiter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		gasl_pkg::value_t drive_level;
		gasl_pkg::value_t right_drive;
		gasl_pkg::value_t left_drive;
	} drive_out_t;

	typedef struct packed {
		bit                 is_cfg;
		gasl_pkg::reg_idx_t idx;
		gasl_pkg::value_t   word_a;
		gasl_pkg::value_t   word_b;
		bit                 fixed;
		drive_out_t         want;
	} row_t;

	localparam drive_out_t NO_FIX = '0;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 110;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [2*gasl_pkg::VALUE_WIDTH-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [3*gasl_pkg::VALUE_WIDTH-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [gasl_pkg::IDX_WIDTH-1:0] cfg_index = '0;
	logic [gasl_pkg::VALUE_WIDTH-1:0] cfg_data = '0;

	gravity_aware_slew_limiter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	// predictor state and register copy
	longint rise_lim = gasl_pkg::ONE_INT / 10;
	longint fall_lim = -(gasl_pkg::ONE_INT / 10);
	longint band_lo = 0;
	longint band_hi = gasl_pkg::ONE_INT / 10;
	longint level_state = 0;

	drive_out_t drive_q [$];
	int error_count = 0;
	int results_seen = 0;
	bit tx_smooth = 1'b0;
	bit rx_smooth = 1'b0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	int tick_count = 0;

	row_t plan [34] = '{
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh0000, 16'sh0000, 1'b1,
			'{16'sh0000, 16'sh0000, 16'sh0000}},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh4000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh4000, 16'sh7FFF, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'shC000, 16'sh8000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh7FFF, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh8000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh0064, 16'sh0005, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_ACCEL_STEP, 16'sh4000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_DECEL_STEP, 16'shC000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_WEAK_LEVEL, 16'shC000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_STRONG_LEVEL, 16'shC000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh7FFF, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh7FFF, 16'sh7FFF, 1'b1,
			'{16'sh4000, 16'sh4000, 16'shC000}},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh7FFF, 16'sh8000, 1'b1,
			'{16'sh4000, 16'shC000, 16'sh4000}},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh8000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh8000, 16'sh0000, 1'b1,
			'{16'shC000, 16'shC000, 16'sh4000}},
		'{1'b1, gasl_pkg::REG_ACCEL_STEP, 16'sh0000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_DECEL_STEP, 16'sh0000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_WEAK_LEVEL, 16'sh4000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh1000, 16'sh0100, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'shF000, 16'shFF00, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_ACCEL_STEP, 16'shFFFF, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_DECEL_STEP, 16'sh3FFF, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_STRONG_LEVEL, 16'sh4000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh2000, 16'sh1234, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'shE000, 16'shEDCC, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh7FFF, 16'sh8000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_ACCEL_STEP, 16'sh0666, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_DECEL_STEP, 16'shF99A, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_WEAK_LEVEL, 16'sh0000, 16'sh0000, 1'b0, NO_FIX},
		'{1'b1, gasl_pkg::REG_STRONG_LEVEL, 16'sh0666, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh0400, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'sh0800, 16'sh0000, 1'b0, NO_FIX},
		'{1'b0, gasl_pkg::REG_ACCEL_STEP, 16'shFC00, 16'sh0000, 1'b0, NO_FIX}
	};

	function automatic longint sat_one(longint v);
		if (v > gasl_pkg::ONE_INT) begin
			return gasl_pkg::ONE_INT;
		end
		if (v < -gasl_pkg::ONE_INT) begin
			return -gasl_pkg::ONE_INT;
		end
		return v;
	endfunction

	function automatic drive_out_t limit_tick(gasl_pkg::value_t req_v,
		gasl_pkg::value_t corr_v);
		longint req;
		longint corr;
		longint cur;
		longint gap;
		longint nxt;
		drive_out_t r;
		req = longint'(req_v);
		corr = longint'(corr_v);
		cur = level_state;
		gap = req - cur;
		if (gap > 0) begin
			if (gap < rise_lim) begin
				nxt = req;
			end else if (cur + rise_lim > band_lo && cur < band_hi) begin
				// rising into the hold band, jump past it
				if (cur > band_lo) begin
					nxt = (req < band_hi + rise_lim) ? req : band_hi + rise_lim;
				end else begin
					nxt = (req < band_hi) ? req : cur + rise_lim + band_hi - band_lo;
				end
			end else begin
				nxt = cur + rise_lim;
			end
		end else begin
			if (gap > fall_lim) begin
				nxt = req;
			end else if (cur + fall_lim < band_hi && cur > band_lo) begin
				if (cur < band_hi) begin
					nxt = (req > band_lo + fall_lim) ? req : band_lo + fall_lim;
				end else begin
					nxt = (req > band_lo) ? req : cur + fall_lim - band_hi + band_lo;
				end
			end else begin
				nxt = cur + fall_lim;
			end
		end
		nxt = sat_one(nxt);
		level_state = nxt;
		r.left_drive = gasl_pkg::value_t'(sat_one(-nxt - corr));
		r.right_drive = gasl_pkg::value_t'(sat_one(nxt + corr));
		r.drive_level = gasl_pkg::value_t'(nxt);
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [gasl_pkg::VALUE_WIDTH-1:0] pick_cfg(gasl_pkg::reg_idx_t idx);
		int r;
		r = $urandom_range(0, 9);
		case (idx)
			gasl_pkg::REG_ACCEL_STEP: begin
				case (r)
					0: return 16'h0000;
					1: return 16'h4000;
					2: return 16'(gasl_pkg::ACCEL_RESET);
					3: return 16'($urandom);
					default: return 16'($urandom_range(0, 16384));
				endcase
			end
			gasl_pkg::REG_DECEL_STEP: begin
				case (r)
					0: return 16'h0000;
					1: return 16'hC000;
					2: return 16'(gasl_pkg::DECEL_RESET);
					3: return 16'($urandom);
					default: return 16'(-$urandom_range(0, 16384));
				endcase
			end
			default: begin
				case (r)
					0: return 16'hC000;
					1: return 16'h4000;
					2: return (idx == gasl_pkg::REG_WEAK_LEVEL) ? gasl_pkg::WEAK_RESET :
						gasl_pkg::STRONG_RESET;
					3: return 16'($urandom);
					default: return 16'(int'($urandom_range(0, 32768)) - 16384);
				endcase
			end
		endcase
	endfunction

	task automatic send_item(gasl_pkg::value_t tgt, gasl_pkg::value_t corr, bit fixed,
		drive_out_t want);
		int gap;
		drive_out_t pred;
		gap = tx_smooth ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {corr, tgt};
		do @(posedge clk); while (!s_axis_tready);
		pred = limit_tick(tgt, corr);
		drive_q.push_back(fixed ? want : pred);
	endtask

	// stop offering and wait until every pending result has left
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(gasl_pkg::reg_idx_t idx,
		logic [gasl_pkg::VALUE_WIDTH-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			gasl_pkg::REG_ACCEL_STEP: rise_lim = longint'(data[gasl_pkg::VALUE_WIDTH-2:0]);
			gasl_pkg::REG_DECEL_STEP:
				fall_lim = longint'($signed(data[gasl_pkg::VALUE_WIDTH-2:0]));
			gasl_pkg::REG_WEAK_LEVEL: band_lo = longint'($signed(data));
			gasl_pkg::REG_STRONG_LEVEL: band_hi = longint'($signed(data));
			default: begin
			end
		endcase
	endtask

	// receiver: random stalls, one long hold-off to back the block up
	always @(posedge clk) begin
		tick_count <= tick_count + 1;
		if (tick_count % 256 == 255) begin
			rx_smooth <= ($urandom_range(0, 3) == 0);
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 400) begin
			long_hold_done <= 1'b1;
			hold_left <= 300;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			hold_left <= rx_smooth ? 0 : idle_len();
		end
	end

	always @(posedge clk) begin
		drive_out_t got;
		drive_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			results_seen <= results_seen + 1;
			if (drive_q.size() == 0) begin
				$error("result transfer with nothing pending: %h", m_axis_tdata);
				error_count++;
			end else begin
				want = drive_q.pop_front();
				if (got.left_drive !== want.left_drive) begin
					$error("left_drive expected %0d actual %0d", want.left_drive, got.left_drive);
					error_count++;
				end
				if (got.right_drive !== want.right_drive) begin
					$error("right_drive expected %0d actual %0d", want.right_drive,
						got.right_drive);
					error_count++;
				end
				if (got.drive_level !== want.drive_level) begin
					$error("drive_level expected %0d actual %0d", want.drive_level,
						got.drive_level);
					error_count++;
				end
			end
		end
	end

	initial begin
		gasl_pkg::value_t hold_target;
		gasl_pkg::value_t tgt;
		gasl_pkg::value_t corr;
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].idx, plan[i].word_a);
			end else begin
				send_item(plan[i].word_a, plan[i].word_b, plan[i].fixed, plan[i].want);
			end
		end

		hold_target = '0;
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			write_reg(gasl_pkg::REG_ACCEL_STEP, pick_cfg(gasl_pkg::REG_ACCEL_STEP));
			write_reg(gasl_pkg::REG_DECEL_STEP, pick_cfg(gasl_pkg::REG_DECEL_STEP));
			write_reg(gasl_pkg::REG_WEAK_LEVEL, pick_cfg(gasl_pkg::REG_WEAK_LEVEL));
			write_reg(gasl_pkg::REG_STRONG_LEVEL, pick_cfg(gasl_pkg::REG_STRONG_LEVEL));
			tx_smooth = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// requests held for runs so the level ramps through the band
				if ($urandom_range(0, 9) < 3) begin
					r = $urandom_range(0, 9);
					case (r)
						0: hold_target = gasl_pkg::value_t'($urandom);
						1: hold_target = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
						2: hold_target = gasl_pkg::value_t'(band_lo +
							int'($urandom_range(0, 64)) - 32);
						3: hold_target = gasl_pkg::value_t'(band_hi +
							int'($urandom_range(0, 64)) - 32);
						default: hold_target = gasl_pkg::value_t'(
							int'($urandom_range(0, 32768)) - 16384);
					endcase
				end
				tgt = hold_target;
				if ($urandom_range(0, 3) == 0) begin
					corr = gasl_pkg::value_t'($urandom);
				end else begin
					corr = gasl_pkg::value_t'(int'($urandom_range(0, 8192)) - 4096);
				end
				send_item(tgt, corr, 1'b0, NO_FIX);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/gasl_pkg.sv
src/gasl_cfg.sv
src/gasl_step.sv
src/gravity_aware_slew_limiter.sv
sim/gravity_aware_slew_limiter_tb.sv
